/* sv/account_object_association_table_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the account/object association table
// Concurrent check wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ACCOUNT_OBJECT_ASSOCIATION_TABLE_UNIT_DEFINES_SVH
`define ACCOUNT_OBJECT_ASSOCIATION_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define AOAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// next-cycle implication
`define AOAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define AOAT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AOAT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/aoat_pkg.sv */
// ----------------------------------------------------------------------------
// aoat_pkg
// Types and constants shared by the association table and its entry store.
// ----------------------------------------------------------------------------
package aoat_pkg;

   localparam int AOAT_TABLE_DEPTH = 64;

   localparam int ACCOUNT_W = 31;
   localparam int OBJECT_W  = 28;
   localparam int COUNT_W   = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // operation codes carried in func
   typedef enum logic [3:0] {
      FN_ASSOCIATE      = 4'd0,
      FN_RENAME_OBJECT  = 4'd1,
      FN_RENAME_ACCOUNT = 4'd2,
      FN_DELETE_ACCOUNT = 4'd3,
      FN_DELETE_OBJECT  = 4'd4,
      FN_COUNT          = 4'd5,
      FN_LOOKUP         = 4'd6,
      FN_FIRST_ACCOUNT  = 4'd7,
      FN_CLEAR          = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // one stored pair
   typedef struct packed {
      logic [ACCOUNT_W-1:0] account;
      logic [OBJECT_W-1:0]  object;
   } entry_type;

endpackage

/* sv/account_object_association_table_unit.sv */
// ----------------------------------------------------------------------------
// account_object_association_table_unit
// Bounded table of (account, object) pairs with insert, rename, delete,
// count, search and clear operations, one result per request.
// ----------------------------------------------------------------------------
// Pairs live in one memory in insertion order (slot fill-1 is the newest), and
// a fill count marks the valid prefix, so reset and clear need no sweep of
// the memory. Every request except clear and unused codes walks the valid
// entries through the single read port and one shared comparator, one entry
// per cycle; the read port sets the rate. Deletes compact survivors in place
// during the walk. The request side is not ready while an operation runs; a
// result waits in the output register while the next request is taken.
`include "account_object_association_table_unit_defines.svh"

module account_object_association_table_unit #(
   parameter int TABLE_DEPTH = aoat_pkg::AOAT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request: func[3:0], account[34:4], object[62:35],
   //          new_value[93:63], zero fill[95:94]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   // response: status[1:0], match_count[8:2], found_account[39:9],
   //           found_object[67:40], zero fill[71:68]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata
);
   import aoat_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;

   // latched request
   func_type             func_ff, func_in;
   logic [ACCOUNT_W-1:0] acc_ff, acc_in;
   logic [OBJECT_W-1:0]  obj_ff, obj_in;
   logic [ACCOUNT_W-1:0] nv_ff, nv_in;

   // table and walk control
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      wptr_ff, wptr_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               dup_ff, dup_in;
   logic               hit_ff, hit_in;
   entry_type          hit_data_ff, hit_data_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ACCOUNT_W-1:0] facc_ff, facc_in;
   logic [OBJECT_W-1:0]  fobj_ff, fobj_in;

   // memory ports
   logic      wr_en;
   logic [AW-1:0] wr_addr;
   entry_type wr_data;
   logic      rd_en;
   logic [AW-1:0] rd_addr;
   entry_type rd_data;

   logic                 by_obj;
   logic [ACCOUNT_W-1:0] cmp_field;
   logic [ACCOUNT_W-1:0] cmp_key;
   logic                 match;
   logic                 req_xfer;

   aoat_store #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // shared comparator: object or account key against the entry just read
   assign by_obj    = func_ff inside {FN_ASSOCIATE, FN_RENAME_OBJECT, FN_DELETE_OBJECT,
                                      FN_LOOKUP};
   assign cmp_field = by_obj ? {3'b000, rd_data.object} : rd_data.account;
   assign cmp_key   = by_obj ? {3'b000, obj_ff} : acc_ff;
   assign match     = (cmp_field == cmp_key);

   // sequencer: next state, walk datapath and result
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      acc_in       = acc_ff;
      obj_in       = obj_ff;
      nv_in        = nv_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cnt_in       = cnt_ff;
      dup_in       = dup_ff;
      hit_in       = hit_ff;
      hit_data_in  = hit_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      count_in     = count_ff;
      facc_in      = facc_ff;
      fobj_in      = fobj_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               func_in = func_type'(req_tdata[3:0]);
               acc_in  = req_tdata[34:4];
               obj_in  = req_tdata[62:35];
               nv_in   = req_tdata[93:63];
               idx_in  = '0;
               wptr_in = '0;
               cnt_in  = '0;
               dup_in  = 1'b0;
               hit_in  = 1'b0;
               if (req_tdata[3:0] <= 4'(FN_FIRST_ACCOUNT)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_SCAN: begin
            // issue the next read
            if (idx_ff < fill_ff) begin
               rd_en        = 1'b1;
               idx_in       = idx_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
            end else if (!pend_ff) begin
               state_in = S_FINISH;
            end
            // handle the entry read in the previous cycle
            if (pend_ff) begin
               case (func_ff)
                  FN_ASSOCIATE: begin
                     if (match) begin
                        dup_in = 1'b1;
                     end
                  end
                  FN_RENAME_OBJECT: begin
                     wr_en          = match;
                     wr_data.object = nv_ff[OBJECT_W-1:0];
                  end
                  FN_RENAME_ACCOUNT: begin
                     wr_en           = match;
                     wr_data.account = nv_ff;
                  end
                  FN_DELETE_ACCOUNT, FN_DELETE_OBJECT: begin
                     if (match) begin
                        if (cnt_ff != COUNT_MAX) begin
                           cnt_in = cnt_ff + 1'b1;
                        end
                     end else begin
                        // compact the survivor down to the write pointer
                        wr_en   = 1'b1;
                        wr_addr = wptr_ff[AW-1:0];
                        wptr_in = wptr_ff + 1'b1;
                     end
                  end
                  FN_COUNT: begin
                     if (match && cnt_ff != COUNT_MAX) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  FN_LOOKUP, FN_FIRST_ACCOUNT: begin
                     // ascending walk: the last hit is the newest
                     if (match) begin
                        hit_in      = 1'b1;
                        hit_data_in = rd_data;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               status_in    = ST_OK;
               count_in     = '0;
               facc_in      = '0;
               fobj_in      = '0;
               unique case (func_ff)
                  FN_ASSOCIATE: begin
                     if (dup_ff) begin
                        status_in = ST_DUPLICATE;
                     end else if (fill_ff == DEPTH_C) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en           = 1'b1;
                        wr_addr         = fill_ff[AW-1:0];
                        wr_data.account = acc_ff;
                        wr_data.object  = obj_ff;
                        fill_in         = fill_ff + 1'b1;
                     end
                  end
                  FN_DELETE_ACCOUNT, FN_DELETE_OBJECT: begin
                     fill_in  = wptr_ff;
                     count_in = cnt_ff;
                  end
                  FN_COUNT: begin
                     count_in = cnt_ff;
                  end
                  FN_LOOKUP: begin
                     if (hit_ff) begin
                        facc_in = hit_data_ff.account;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  FN_FIRST_ACCOUNT: begin
                     if (hit_ff) begin
                        fobj_in = hit_data_ff.object;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  FN_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      acc_ff       <= acc_in;
      obj_ff       <= obj_in;
      nv_ff        <= nv_in;
      idx_ff       <= idx_in;
      wptr_ff      <= wptr_in;
      pend_addr_ff <= pend_addr_in;
      cnt_ff       <= cnt_in;
      dup_ff       <= dup_in;
      hit_ff       <= hit_in;
      hit_data_ff  <= hit_data_in;
      status_ff    <= status_in;
      count_ff     <= count_in;
      facc_ff      <= facc_in;
      fobj_ff      <= fobj_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, fobj_ff, facc_ff, count_ff, status_ff};

   // checks
   `AOAT_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= DEPTH_C)
   `AOAT_ASSERT_IMPL(a_walk_bound, clock, reset, state_ff == S_SCAN, idx_ff <= fill_ff)
   `AOAT_ASSERT_IMPL(a_compact_behind, clock, reset,
      state_ff == S_SCAN && pend_ff, wptr_ff <= CW'(pend_addr_ff))
   `AOAT_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, state_ff != S_IDLE)

endmodule

/* sv/aoat_store.sv */
// ----------------------------------------------------------------------------
// aoat_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aoat_store #(
   parameter int DEPTH = aoat_pkg::AOAT_TABLE_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  aoat_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output aoat_pkg::entry_type rd_data
);
   import aoat_pkg::*;

   entry_type mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
